[rtl/core/hrp_pkg.sv]
// Shared types, constants and helpers for the HTTP response header parser.
`timescale 1ns / 1ps

package hrp_pkg;

  localparam int LENGTH_BITS = 48;
  localparam int OUT_BITS    = 19 + LENGTH_BITS;
  localparam int OUT_BYTES   = (OUT_BITS + 7) / 8;

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [3:0] LEN_NAME_LEN  = 4'd14;
  localparam logic [3:0] HTTP_NAME_LEN = 4'd4;
  localparam logic [3:0] POS_MAX       = 4'd15;

  typedef enum logic [2:0] {
    PH_STATUS  = 3'd0,
    PH_HEADERS = 3'd1,
    PH_BODY    = 3'd2,
    PH_DONE    = 3'd3,
    PH_ERROR   = 3'd4
  } phase_t;

  // status line and header line states share one register
  typedef enum logic [4:0] {
    S_START, S_H, S_HT, S_HTT, S_HTTP, S_MAJ1, S_MAJ, S_MIN1, S_MIN,
    S_CODE, S_AFTER_CODE, S_TEXT, S_ALMOST,
    H_START, H_NAME, H_SP_BEFORE, H_VALUE, H_SP_AFTER, H_IGNORE,
    H_ALMOST, H_END_ALMOST
  } line_t;

  typedef enum logic [1:0] {
    FORM_EMPTY  = 2'd0,
    FORM_DIGITS = 2'd1,
    FORM_BAD    = 2'd2
  } form_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_STATUS   = 2'd1,
    ERR_LINE_END = 2'd2,
    ERR_LENGTH   = 2'd3
  } err_t;

  typedef struct packed {
    phase_t                 phase;
    line_t                  line;
    logic [9:0]             code;
    logic [1:0]             digits;
    logic [LENGTH_BITS-1:0] body_left;
    logic [3:0]             pos;
    logic                   match_len;
    logic                   match_http;
    logic [LENGTH_BITS-1:0] value_num;
    form_t                  form;
    err_t                   err;
  } hrp_state_t;

  typedef struct packed {
    logic [2:0]             phase;
    logic [9:0]             resp_code;
    logic                   status_valid;
    logic                   header_line_done;
    logic [LENGTH_BITS-1:0] remaining_length;
    logic                   body_byte;
    logic                   response_done;
    logic [1:0]             error_code;
  } hrp_result_t;

  localparam hrp_state_t STATE_RESET = '{
    phase:      PH_STATUS,
    line:       S_START,
    code:       10'd0,
    digits:     2'd0,
    body_left:  '0,
    pos:        4'd0,
    match_len:  1'b0,
    match_http: 1'b0,
    value_num:  '0,
    form:       FORM_EMPTY,
    err:        ERR_NONE
  };

  function automatic logic [7:0] len_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "C";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "L";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] http_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "H";
      4'd1:    c = "T";
      4'd2:    c = "T";
      4'd3:    c = "P";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/hrp_step.sv]
// Per-byte next-state and result logic of the parser.
`timescale 1ns / 1ps

module hrp_step
  import hrp_pkg::*;
(
  input  hrp_state_t  cur,
  input  logic [7:0]  ch,
  input  logic        restart,
  output hrp_state_t  nxt,
  output hrp_result_t res
);

  hrp_state_t s;
  logic       is_digit;
  logic [3:0] dig;
  logic [9:0] code_sum;
  logic [LENGTH_BITS+3:0] val_sum;
  logic       val_ovf;
  logic       line_done;
  logic       body;
  logic       done;
  logic       end_line;

  assign s        = restart ? STATE_RESET : cur;
  assign is_digit = (ch >= "0") && (ch <= "9");
  assign dig      = ch[3:0];
  assign code_sum = {s.code[6:0], 3'b000} + {s.code[8:0], 1'b0} + {6'd0, dig};
  assign val_sum  = {1'b0, s.value_num, 3'b000} + {3'b000, s.value_num, 1'b0}
                  + {{LENGTH_BITS{1'b0}}, dig};
  assign val_ovf  = |val_sum[LENGTH_BITS+3:LENGTH_BITS];

  always_comb begin
    nxt       = s;
    line_done = 1'b0;
    body      = 1'b0;
    done      = 1'b0;
    end_line  = 1'b0;

    case (s.phase)
      PH_STATUS: begin
        case (s.line)
          S_START:  if (ch == "H") nxt.line = S_H;    else nxt.phase = PH_ERROR;
          S_H:      if (ch == "T") nxt.line = S_HT;   else nxt.phase = PH_ERROR;
          S_HT:     if (ch == "T") nxt.line = S_HTT;  else nxt.phase = PH_ERROR;
          S_HTT:    if (ch == "P") nxt.line = S_HTTP; else nxt.phase = PH_ERROR;
          S_HTTP:   if (ch == "/") nxt.line = S_MAJ1; else nxt.phase = PH_ERROR;
          S_MAJ1: begin
            if (ch >= "1" && ch <= "9") nxt.line = S_MAJ;
            else nxt.phase = PH_ERROR;
          end
          S_MAJ: begin
            if (ch == ".") nxt.line = S_MIN1;
            else if (!is_digit) nxt.phase = PH_ERROR;
          end
          S_MIN1:   if (is_digit) nxt.line = S_MIN; else nxt.phase = PH_ERROR;
          S_MIN: begin
            if (ch == " ") nxt.line = S_CODE;
            else if (!is_digit) nxt.phase = PH_ERROR;
          end
          S_CODE: begin
            if (ch != " ") begin
              if (!is_digit) begin
                nxt.phase = PH_ERROR;
              end else begin
                nxt.code   = code_sum;
                nxt.digits = s.digits + 2'd1;
                if (s.digits == 2'd2) nxt.line = S_AFTER_CODE;
              end
            end
          end
          S_AFTER_CODE: begin
            if (ch == " " || ch == ".") nxt.line = S_TEXT;
            else if (ch == CH_CR) nxt.line = S_ALMOST;
            else if (ch == CH_LF) begin
              nxt.phase = PH_HEADERS;
              nxt.line  = H_START;
            end else nxt.phase = PH_ERROR;
          end
          S_TEXT: begin
            if (ch == CH_CR) nxt.line = S_ALMOST;
            else if (ch == CH_LF) begin
              nxt.phase = PH_HEADERS;
              nxt.line  = H_START;
            end
          end
          S_ALMOST: begin
            if (ch == CH_LF) begin
              nxt.phase = PH_HEADERS;
              nxt.line  = H_START;
            end else nxt.phase = PH_ERROR;
          end
          default: nxt.line = S_START;
        endcase
        if (nxt.phase == PH_ERROR) nxt.err = ERR_STATUS;
      end

      PH_HEADERS: begin
        case (s.line)
          H_START: begin
            if (ch == CH_CR) nxt.line = H_END_ALMOST;
            else if (ch == CH_LF) nxt.phase = PH_BODY;
            else begin
              nxt.line       = H_NAME;
              nxt.pos        = 4'd1;
              nxt.match_len  = (ch == len_char(4'd0));
              nxt.match_http = (ch == http_char(4'd0));
              nxt.value_num  = '0;
              nxt.form       = FORM_EMPTY;
            end
          end
          H_IGNORE: if (ch == CH_LF) nxt.line = H_START;
          H_END_ALMOST: begin
            if (ch == CH_LF) nxt.phase = PH_BODY;
            else begin
              nxt.phase = PH_ERROR;
              nxt.err   = ERR_LINE_END;
            end
          end
          default: begin
            if (s.pos < LEN_NAME_LEN && ch != len_char(s.pos)) nxt.match_len = 1'b0;
            if (s.pos < HTTP_NAME_LEN && ch != http_char(s.pos)) nxt.match_http = 1'b0;
            if (s.pos < POS_MAX) nxt.pos = s.pos + 4'd1;

            case (s.line)
              H_NAME: begin
                if (ch == ":") nxt.line = H_SP_BEFORE;
                else if (ch == CH_CR) nxt.line = H_ALMOST;
                else if (ch == CH_LF) end_line = 1'b1;
                else if (ch == "/" && s.pos == HTTP_NAME_LEN && nxt.match_http)
                  nxt.line = H_IGNORE;
              end
              H_SP_BEFORE, H_VALUE: begin
                if (ch == " ") begin
                  if (s.line == H_VALUE) nxt.line = H_SP_AFTER;
                end else if (ch == CH_CR) nxt.line = H_ALMOST;
                else if (ch == CH_LF) end_line = 1'b1;
                else begin
                  nxt.line = H_VALUE;
                  if (s.form != FORM_BAD) begin
                    if (!is_digit || val_ovf) nxt.form = FORM_BAD;
                    else begin
                      nxt.value_num = val_sum[LENGTH_BITS-1:0];
                      nxt.form      = FORM_DIGITS;
                    end
                  end
                end
              end
              H_SP_AFTER: begin
                if (ch == CH_CR) nxt.line = H_ALMOST;
                else if (ch == CH_LF) end_line = 1'b1;
                else if (ch != " ") begin
                  nxt.form = FORM_BAD;
                  nxt.line = H_VALUE;
                end
              end
              H_ALMOST: begin
                if (ch == CH_LF) end_line = 1'b1;
                else if (ch != CH_CR) begin
                  nxt.phase = PH_ERROR;
                  nxt.err   = ERR_LINE_END;
                end
              end
              default: nxt.line = H_START;
            endcase

            if (end_line) begin
              nxt.line  = H_START;
              line_done = 1'b1;
              if (nxt.match_len && nxt.pos >= LEN_NAME_LEN && s.body_left == '0) begin
                if (s.form != FORM_DIGITS) begin
                  nxt.phase = PH_ERROR;
                  nxt.err   = ERR_LENGTH;
                  line_done = 1'b0;
                end else begin
                  nxt.body_left = s.value_num;
                end
              end
            end
          end
        endcase
        // headers ended with no body expected
        if (nxt.phase == PH_BODY && nxt.body_left == '0) begin
          nxt.phase = PH_DONE;
          done      = 1'b1;
        end
      end

      PH_BODY: begin
        body = 1'b1;
        if (s.body_left != '0) nxt.body_left = s.body_left - 1'b1;
        if (nxt.body_left == '0) begin
          nxt.phase = PH_DONE;
          done      = 1'b1;
        end
      end

      default: ;
    endcase
  end

  always_comb begin
    res.phase            = nxt.phase;
    res.resp_code        = nxt.code;
    res.status_valid     = (nxt.phase == PH_HEADERS) || (nxt.phase == PH_BODY) ||
                           (nxt.phase == PH_DONE) ||
                           (nxt.phase == PH_ERROR && nxt.err != ERR_STATUS);
    res.header_line_done = line_done;
    res.remaining_length = nxt.body_left;
    res.body_byte        = body;
    res.response_done    = done;
    res.error_code       = (nxt.phase == PH_ERROR) ? nxt.err : ERR_NONE;
  end

endmodule

[rtl/core/http_response_header_parser.sv]
// A byte's result is registered: it appears on out_* in the cycle after the byte is accepted.
// The parser takes one byte per cycle while in_tready is high; the parse state and result register update together.
// A new byte is taken while the result register is empty or being drained.
// Reset (rst_n low, synchronous) returns the parser to the start of the status line
// and empties the result register.
`timescale 1ns / 1ps

module http_response_header_parser
  import hrp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // data_byte
  input  logic                   in_tuser,   // restart
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // phase[2:0], resp_code[12:3], status_valid[13], header_line_done[14],
  // remaining_length[62:15], body_byte[63], response_done[64], error_code[66:65]
  output logic [OUT_BYTES*8-1:0] out_tdata
);

  hrp_state_t  state_r;
  hrp_state_t  state_nxt;
  hrp_result_t res;
  logic        out_valid_r;
  logic [OUT_BYTES*8-1:0] out_data_r;
  logic [OUT_BYTES*8-1:0] out_data_nxt;
  logic        in_xfer;

  hrp_step u_step (
    .cur     (state_r),
    .ch      (in_tdata),
    .restart (in_tuser),
    .nxt     (state_nxt),
    .res     (res)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[2:0]                = res.phase;
    out_data_nxt[12:3]               = res.resp_code;
    out_data_nxt[13]                 = res.status_valid;
    out_data_nxt[14]                 = res.header_line_done;
    out_data_nxt[LENGTH_BITS+14:15]  = res.remaining_length;
    out_data_nxt[LENGTH_BITS+15]     = res.body_byte;
    out_data_nxt[LENGTH_BITS+16]     = res.response_done;
    out_data_nxt[LENGTH_BITS+18:LENGTH_BITS+17] = res.error_code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[test/testbench.sv]
// Self-checking stream testbench for the HTTP response header parser.
`timescale 1ns / 1ps

module testbench;
  import hrp_pkg::*;

  localparam int ITEM_TARGET = 950;
  localparam int SCRIPT_LEN  = 18;

  localparam logic [8*14-1:0] LENGTH_NAME = "Content-Length";
  localparam logic [8*4-1:0]  HTTP_NAME   = "HTTP";

  // same bit order as out_tdata, phase in the lowest bits
  typedef struct packed {
    logic [1:0]             err;
    logic                   done;
    logic                   body;
    logic [LENGTH_BITS-1:0] left;
    logic                   line_done;
    logic                   valid;
    logic [9:0]             code;
    logic [2:0]             phase;
  } parse_result_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       restart;
    logic       pinned;
    phase_t     phase;
    err_t       err;
  } script_row_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = 8'h00;   // data_byte
  logic                   in_tuser = 1'b0;    // restart
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // phase, resp_code, status_valid, header_line_done, remaining_length,
  // body_byte, response_done, error_code
  logic [OUT_BYTES*8-1:0] out_tdata;

  http_response_header_parser u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // parser state as predicted
  phase_t                 p_phase;
  line_t                  p_line;
  logic [9:0]             p_code;
  logic [1:0]             p_digits;
  logic [LENGTH_BITS-1:0] p_left;
  logic [3:0]             p_pos;
  logic                   p_len_hit;
  logic                   p_http_hit;
  logic [LENGTH_BITS-1:0] p_value;
  form_t                  p_form;
  err_t                   p_err;

  parse_result_t pending_results[$];
  logic [7:0]    frame_bytes[$];
  logic          frame_restart[$];

  int mismatches;
  int results_seen;
  int live_bytes;
  int ignored_bytes;
  int stream_count;
  int line_count;
  int body_count;
  int done_count;
  int error_count;
  bit send_calm;

  // status line: an error at the first byte, then a clean line that runs to its LF; ERR_NONE stays clean
  script_row_t script_rows [SCRIPT_LEN] = '{
    '{8'hFF, 1'b1, 1'b1, PH_ERROR,   ERR_STATUS},  // first byte not 'H'
    '{8'h00, 1'b0, 1'b1, PH_ERROR,   ERR_STATUS},  // error holds until restart
    '{"H",   1'b1, 1'b1, PH_STATUS,  ERR_NONE},
    '{"T",   1'b0, 1'b0, PH_STATUS,  ERR_NONE},
    '{"T",   1'b0, 1'b0, PH_STATUS,  ERR_NONE},
    '{"P",   1'b0, 1'b0, PH_STATUS,  ERR_NONE},
    '{"/",   1'b0, 1'b0, PH_STATUS,  ERR_NONE},
    '{"9",   1'b0, 1'b0, PH_STATUS,  ERR_NONE},
    '{".",   1'b0, 1'b0, PH_STATUS,  ERR_NONE},
    '{"0",   1'b0, 1'b0, PH_STATUS,  ERR_NONE},
    '{" ",   1'b0, 1'b0, PH_STATUS,  ERR_NONE},
    '{"9",   1'b0, 1'b0, PH_STATUS,  ERR_NONE},
    '{"9",   1'b0, 1'b0, PH_STATUS,  ERR_NONE},
    '{"9",   1'b0, 1'b0, PH_STATUS,  ERR_NONE},
    '{CH_LF, 1'b0, 1'b1, PH_HEADERS, ERR_NONE},
    '{CH_CR, 1'b0, 1'b0, PH_HEADERS, ERR_NONE},
    '{CH_LF, 1'b0, 1'b1, PH_DONE,    ERR_NONE},    // no length: done at blank line
    '{8'hFF, 1'b0, 1'b1, PH_DONE,    ERR_NONE}     // ignored once done
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int idle_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void fault(input string field, input longint unsigned want,
                                input longint unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s at result %0d: expected %0h, got %0h",
               field, results_seen, want, got);
  endfunction

  function automatic void parser_clear();
    p_phase    = PH_STATUS;
    p_line     = S_START;
    p_code     = '0;
    p_digits   = '0;
    p_left     = '0;
    p_pos      = '0;
    p_len_hit  = 1'b0;
    p_http_hit = 1'b0;
    p_value    = '0;
    p_form     = FORM_EMPTY;
    p_err      = ERR_NONE;
  endfunction

  function automatic void raise(input err_t e);
    p_phase = PH_ERROR;
    p_err   = e;
  endfunction

  function automatic bit is_digit(input logic [7:0] ch);
    return ch >= "0" && ch <= "9";
  endfunction

  function automatic void value_digit(input logic [7:0] ch);
    logic [63:0] d;
    logic [63:0] lim;
    if (p_form == FORM_BAD) return;
    if (!is_digit(ch)) begin
      p_form = FORM_BAD;
      return;
    end
    d   = 64'(ch - "0");
    lim = (64'd1 << LENGTH_BITS) - 64'd1;
    if (64'(p_value) > (lim - d) / 64'd10) begin
      p_form = FORM_BAD;
      return;
    end
    p_value = LENGTH_BITS'(64'(p_value) * 64'd10 + d);
    p_form  = FORM_DIGITS;
  endfunction

  // a header line ended; a matching length line loads the body count
  function automatic bit line_close();
    p_line = H_START;
    if (p_len_hit && p_pos >= LEN_NAME_LEN && p_left == '0) begin
      if (p_form != FORM_DIGITS) begin
        raise(ERR_LENGTH);
        return 1'b0;
      end
      p_left = p_value;
    end
    return 1'b1;
  endfunction

  function automatic void status_step(input logic [7:0] ch);
    case (p_line)
      S_START: if (ch == "H") p_line = S_H; else raise(ERR_STATUS);
      S_H:     if (ch == "T") p_line = S_HT; else raise(ERR_STATUS);
      S_HT:    if (ch == "T") p_line = S_HTT; else raise(ERR_STATUS);
      S_HTT:   if (ch == "P") p_line = S_HTTP; else raise(ERR_STATUS);
      S_HTTP:  if (ch == "/") p_line = S_MAJ1; else raise(ERR_STATUS);
      S_MAJ1:  if (ch >= "1" && ch <= "9") p_line = S_MAJ; else raise(ERR_STATUS);
      S_MAJ: begin
        if (ch == ".") p_line = S_MIN1;
        else if (!is_digit(ch)) raise(ERR_STATUS);
      end
      S_MIN1:  if (is_digit(ch)) p_line = S_MIN; else raise(ERR_STATUS);
      S_MIN: begin
        if (ch == " ") p_line = S_CODE;
        else if (!is_digit(ch)) raise(ERR_STATUS);
      end
      S_CODE: begin
        if (ch != " ") begin
          if (!is_digit(ch)) raise(ERR_STATUS);
          else begin
            p_code   = 10'(p_code * 10 + (ch - "0"));
            p_digits = p_digits + 2'd1;
            if (p_digits == 2'd3) p_line = S_AFTER_CODE;
          end
        end
      end
      S_AFTER_CODE: begin
        if (ch == " " || ch == ".") p_line = S_TEXT;
        else if (ch == CH_CR) p_line = S_ALMOST;
        else if (ch == CH_LF) begin
          p_phase = PH_HEADERS;
          p_line  = H_START;
        end else raise(ERR_STATUS);
      end
      S_TEXT: begin
        if (ch == CH_CR) p_line = S_ALMOST;
        else if (ch == CH_LF) begin
          p_phase = PH_HEADERS;
          p_line  = H_START;
        end
      end
      S_ALMOST: begin
        if (ch == CH_LF) begin
          p_phase = PH_HEADERS;
          p_line  = H_START;
        end else raise(ERR_STATUS);
      end
      default: p_line = S_START;
    endcase
  endfunction

  // returns 1 when the byte completed a header line without a length error
  function automatic bit header_step(input logic [7:0] ch);
    int pos;
    if (p_line == H_START) begin
      if (ch == CH_CR) begin
        p_line = H_END_ALMOST;
        return 1'b0;
      end
      if (ch == CH_LF) begin
        p_phase = PH_BODY;
        return 1'b0;
      end
      p_line     = H_NAME;
      p_pos      = 4'd1;
      p_len_hit  = (ch == LENGTH_NAME[8*13 +: 8]);
      p_http_hit = (ch == HTTP_NAME[8*3 +: 8]);
      p_value    = '0;
      p_form     = FORM_EMPTY;
      return 1'b0;
    end
    if (p_line == H_IGNORE) begin
      if (ch == CH_LF) p_line = H_START;
      return 1'b0;
    end
    if (p_line == H_END_ALMOST) begin
      if (ch == CH_LF) p_phase = PH_BODY; else raise(ERR_LINE_END);
      return 1'b0;
    end
    pos = int'(p_pos);
    if (pos < 14) begin
      if (ch != LENGTH_NAME[8*(13-pos) +: 8]) p_len_hit = 1'b0;
    end
    if (pos < 4) begin
      if (ch != HTTP_NAME[8*(3-pos) +: 8]) p_http_hit = 1'b0;
    end
    if (pos < 15) p_pos = 4'(pos + 1);

    case (p_line)
      H_NAME: begin
        if (ch == ":") p_line = H_SP_BEFORE;
        else if (ch == CH_CR) p_line = H_ALMOST;
        else if (ch == CH_LF) return line_close();
        else if (ch == "/" && pos == 4 && p_http_hit) p_line = H_IGNORE;
      end
      H_SP_BEFORE: begin
        if (ch == CH_CR) p_line = H_ALMOST;
        else if (ch == CH_LF) return line_close();
        else if (ch != " ") begin
          value_digit(ch);
          p_line = H_VALUE;
        end
      end
      H_VALUE: begin
        if (ch == " ") p_line = H_SP_AFTER;
        else if (ch == CH_CR) p_line = H_ALMOST;
        else if (ch == CH_LF) return line_close();
        else value_digit(ch);
      end
      H_SP_AFTER: begin
        if (ch == CH_CR) p_line = H_ALMOST;
        else if (ch == CH_LF) return line_close();
        else if (ch != " ") begin
          // a space inside the value spoils it
          p_form = FORM_BAD;
          p_line = H_VALUE;
        end
      end
      H_ALMOST: begin
        if (ch == CH_LF) return line_close();
        if (ch != CH_CR) raise(ERR_LINE_END);
      end
      default: p_line = H_START;
    endcase
    return 1'b0;
  endfunction

  function automatic parse_result_t parse_byte(input logic [7:0] ch, input logic restart);
    parse_result_t r;
    logic line_done;
    logic body;
    logic done;
    line_done = 1'b0;
    body      = 1'b0;
    done      = 1'b0;
    if (restart) parser_clear();
    case (p_phase)
      PH_STATUS: status_step(ch);
      PH_HEADERS: begin
        line_done = header_step(ch);
        if (p_phase == PH_BODY && p_left == '0) begin
          p_phase = PH_DONE;
          done    = 1'b1;
        end
      end
      PH_BODY: begin
        body = 1'b1;
        if (p_left != '0) p_left = p_left - 1'b1;
        if (p_left == '0) begin
          p_phase = PH_DONE;
          done    = 1'b1;
        end
      end
      default: ;
    endcase
    r.phase     = p_phase;
    r.code      = p_code;
    r.valid     = (p_phase == PH_HEADERS || p_phase == PH_BODY || p_phase == PH_DONE ||
                   (p_phase == PH_ERROR && p_err != ERR_STATUS));
    r.line_done = line_done;
    r.left      = p_left;
    r.body      = body;
    r.done      = done;
    r.err       = (p_phase == PH_ERROR) ? p_err : ERR_NONE;
    return r;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    frame_bytes.push_back(b);
    frame_restart.push_back(1'b0);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void put_eol();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      put_byte(CH_CR);
      put_byte(CH_LF);
    end else if (r < 95) begin
      put_byte(CH_LF);
    end else begin
      put_byte(CH_CR);
      put_byte(CH_CR);
      put_byte(CH_LF);
    end
  endfunction

  task automatic send_byte(input logic [7:0] ch, input logic restart, input bit pinned,
                           input phase_t pin_phase, input err_t pin_err);
    parse_result_t want;
    phase_t        prior;
    int            gap;
    gap = idle_len(send_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    prior = p_phase;
    if (restart || (p_phase != PH_DONE && p_phase != PH_ERROR)) live_bytes++;
    else ignored_bytes++;
    want = parse_byte(ch, restart);
    if (want.phase == PH_ERROR && (restart || prior != PH_ERROR)) error_count++;
    line_count += want.line_done;
    body_count += want.body;
    done_count += want.done;
    if (pinned) begin
      want.phase = pin_phase;
      want.err   = pin_err;
    end
    pending_results.push_back(want);
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= restart;
    // handshake inputs are stable at the falling edge
    forever begin
      @(negedge clk);
      if (in_tready) break;
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  initial begin : result_sink
    int hold;
    bit calm;
    hold = 0;
    calm = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
        hold = idle_len(calm);
        if ($urandom_range(0, 149) == 0) calm = !calm;
      end
    end
  end

  initial begin : result_check
    parse_result_t got;
    parse_result_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        results_seen++;
        got = parse_result_t'(out_tdata[OUT_BITS-1:0]);
        if (pending_results.size() == 0) begin
          fault("transfer with nothing pending", 0, got.phase);
        end else begin
          want = pending_results.pop_front();
          if (got.phase !== want.phase)         fault("phase", want.phase, got.phase);
          if (got.code !== want.code)           fault("resp_code", want.code, got.code);
          if (got.valid !== want.valid)         fault("status_valid", want.valid, got.valid);
          if (got.line_done !== want.line_done)
            fault("header_line_done", want.line_done, got.line_done);
          if (got.left !== want.left)           fault("remaining_length", want.left, got.left);
          if (got.body !== want.body)           fault("body_byte", want.body, got.body);
          if (got.done !== want.done)           fault("response_done", want.done, got.done);
          if (got.err !== want.err)             fault("error_code", want.err, got.err);
        end
        if (out_tdata[OUT_BYTES*8-1:OUT_BITS] !== '0)
          fault("tdata padding", 0, out_tdata[OUT_BYTES*8-1:OUT_BITS]);
      end
    end
  end

  initial begin : stimulus
    int          n;
    int          k;
    int          r;
    int          num;
    int          pos;
    int          body_hint;
    string       name;
    string       val;
    logic [7:0]  b;
    script_row_t row;

    parser_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script_rows[i]) begin
      row = script_rows[i];
      send_byte(row.ch, row.restart, row.pinned, row.phase, row.err);
    end

    while (live_bytes + ignored_bytes < ITEM_TARGET) begin
      frame_bytes.delete();
      frame_restart.delete();
      body_hint = -1;
      send_calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 19) == 0) begin
        // line noise
        n = $urandom_range(1, 20);
        repeat (n) put_byte(8'($urandom_range(0, 255)));
      end else begin
        put_text($sformatf("HTTP/%0d.%0d ", $urandom_range(1, 19), $urandom_range(0, 99)));
        repeat ($urandom_range(0, 2)) put_byte(" ");
        for (k = 0; k < 3; k++) begin
          if (k > 0 && $urandom_range(0, 9) == 0) put_byte(" ");
          put_byte(8'("0" + $urandom_range(0, 9)));
        end
        case ($urandom_range(0, 3))
          0: begin
            put_byte(CH_CR);
            put_byte(CH_LF);
          end
          1: put_byte(CH_LF);
          default: begin
            put_byte(($urandom_range(0, 1) == 0) ? " " : ".");
            repeat ($urandom_range(0, 8)) begin
              b = 8'($urandom_range(0, 255));
              put_byte((b == CH_CR || b == CH_LF) ? 8'h7F : b);
            end
            put_eol();
          end
        endcase

        n = $urandom_range(0, 5);
        for (k = 0; k < n; k++) begin
          r = $urandom_range(0, 11);
          if (r == 8) begin
            put_text("HTTP/1.1 100 Continue");
          end else if (r == 9) begin
            put_text("Connection");
          end else begin
            if (r < 5) name = "Content-Length";
            else if (r == 5) begin
              case ($urandom_range(0, 2))
                0: name = "Content-LengthX";
                1: name = "Content-Lengt";
                default: name = "content-length";
              endcase
            end else begin
              name = "";
              repeat ($urandom_range(1, 12))
                name = $sformatf("%s%c", name, 8'($urandom_range(97, 122)));
            end
            case ($urandom_range(0, 9))
              0, 1, 2, 3: begin
                num = $urandom_range(1, 40);
                val = $sformatf("%0d", num);
                if (r < 5 && body_hint < 0) body_hint = num;
              end
              4: val = "0";
              5: val = "";
              6: val = $sformatf("%0d%c", $urandom_range(0, 9), 8'($urandom_range(33, 126)));
              7: val = "1 2";
              8: begin
                case ($urandom_range(0, 2))
                  0: val = "281474976710655";
                  1: val = "281474976710656";
                  default: val = "99999999999999999999";
                endcase
              end
              default: val = $sformatf("00%0d", $urandom_range(0, 99999));
            endcase
            put_text({name, ":"});
            repeat ($urandom_range(0, 2)) put_byte(" ");
            put_text(val);
            repeat ($urandom_range(0, 2)) put_byte(" ");
          end
          put_eol();
        end
        put_eol();

        if (body_hint >= 0 && $urandom_range(0, 9) < 7) n = body_hint + $urandom_range(0, 3);
        else n = $urandom_range(0, 30);
        repeat (n) put_byte(8'($urandom_range(0, 255)));
      end

      // some streams get a corrupt byte, a restart part way or are cut short
      if ($urandom_range(0, 9) == 0 && frame_bytes.size() > 1) begin
        pos = $urandom_range(1, frame_bytes.size() - 1);
        case ($urandom_range(0, 2))
          0: frame_bytes[pos] = 8'($urandom_range(0, 255));
          1: frame_restart[pos] = 1'b1;
          default: begin
            while (frame_bytes.size() > pos) begin
              void'(frame_bytes.pop_back());
              void'(frame_restart.pop_back());
            end
          end
        endcase
      end
      frame_restart[0] = ($urandom_range(0, 19) != 0);

      if (stream_count == 0 || $urandom_range(0, 29) == 0) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      stream_count++;
      foreach (frame_bytes[i])
        send_byte(frame_bytes[i], frame_restart[i], 1'b0, PH_STATUS, ERR_NONE);
    end
    in_tvalid <= 1'b0;

    for (k = 0; k < 20000 && pending_results.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      mismatches += pending_results.size();
    end

    $display("Parsed %0d live bytes (%0d ignored) over %0d streams, %0d transfers checked.",
             live_bytes, ignored_bytes, stream_count, results_seen);
    $display("Saw %0d header lines, %0d body bytes, %0d finished responses, %0d parse errors.",
             line_count, body_count, done_count, error_count);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
